FILE: rtl/radio_register_write_shadow_core_assert.svh
`ifndef RADIO_REGISTER_WRITE_SHADOW_CORE_ASSERT_SVH
`define RADIO_REGISTER_WRITE_SHADOW_CORE_ASSERT_SVH

// check a property on every clock edge outside reset
`define RRWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition leads to a consequence after the delay given by n
`define RRWS_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

FILE: rtl/rrws_pkg.sv
package rrws_pkg;

  localparam int LR_COUNT = 60;
  localparam int FSK_COUNT = 76;
  localparam int IDX_W = 7;
  localparam int LR_IDX_W = $clog2(LR_COUNT);
  localparam int FSK_IDX_W = $clog2(FSK_COUNT);
  localparam int FSK_TAIL_COUNT = 13;
  localparam int FSK_TAIL_BASE = 63;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_MODE_RESET = 2'd3;

  localparam logic [6:0] OPMODE_ADDR = 7'h01;
  localparam logic [6:0] FSK_DIRECT_LO = 7'h01;
  localparam logic [6:0] FSK_DIRECT_HI = 7'h3F;
  localparam logic [6:0] SHARED_LO = 7'h0D;
  localparam logic [6:0] SHARED_HI = 7'h3F;
  localparam logic [6:0] LF_LO = 7'h61;
  localparam logic [6:0] LF_HI = 7'h73;

  localparam logic [6:0] LR_ADDRS [LR_COUNT] = '{
    7'h01, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0A, 7'h0B, 7'h0C,
    7'h0D, 7'h0E, 7'h0F, 7'h10, 7'h11, 7'h12, 7'h13, 7'h14,
    7'h15, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1A, 7'h1B, 7'h1C,
    7'h1D, 7'h1E, 7'h1F, 7'h20, 7'h21, 7'h22, 7'h23, 7'h24,
    7'h25, 7'h26, 7'h28, 7'h29, 7'h2A, 7'h2C, 7'h2F, 7'h30,
    7'h31, 7'h33, 7'h36, 7'h37, 7'h39, 7'h3A, 7'h3B, 7'h40,
    7'h41, 7'h42, 7'h44, 7'h4B, 7'h4D, 7'h5B, 7'h5D, 7'h61,
    7'h62, 7'h63, 7'h64, 7'h70
  };

  localparam logic [6:0] FSK_TAIL [FSK_TAIL_COUNT] = '{
    7'h40, 7'h41, 7'h42, 7'h44, 7'h4B, 7'h4D, 7'h5B, 7'h5D,
    7'h61, 7'h62, 7'h63, 7'h64, 7'h70
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] reg_address;
    logic [7:0] write_data;
    logic       read_bank;
  } req_t;

  typedef struct packed {
    logic             bank_used;
    logic             shared_page;
    logic             low_freq_range;
    logic             known_register;
    logic [IDX_W-1:0] entry_index;
    logic             written_flag;
    logic [7:0]       shadow_value;
  } rsp_t;

  typedef struct packed {
    logic             known;
    logic [IDX_W-1:0] idx;
  } lookup_t;

  typedef struct packed {
    logic             clear;
    logic             we;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [7:0]       wdata;
  } shd_ctrl_t;

  function automatic lookup_t rrws_lookup(logic bank, logic [6:0] addr);
    lookup_t r;
    r = '0;
    if (bank) begin
      for (int i = 0; i < LR_COUNT; i++) begin
        if (LR_ADDRS[i] == addr) begin
          r.known = 1'b1;
          r.idx = r.idx | IDX_W'(i);
        end
      end
    end else if (addr >= FSK_DIRECT_LO && addr <= FSK_DIRECT_HI) begin
      r.known = 1'b1;
      r.idx = addr - FSK_DIRECT_LO;
    end else begin
      for (int i = 0; i < FSK_TAIL_COUNT; i++) begin
        if (FSK_TAIL[i] == addr) begin
          r.known = 1'b1;
          r.idx = r.idx | IDX_W'(FSK_TAIL_BASE + i);
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/radio_register_write_shadow_core.sv
// A request accepted at a clock edge is registered into req_q, passes the s2 stage and
// then the output register, which raises the result strobe; one request per cycle,
// busy never rises.
// The rate is set by the register-decode stage feeding one shadow memory port per bank.
// Reset (synchronous, active high) clears the mode flags, sets log enable, drops
// in-flight requests and empties both shadows at once through per-entry written bits.
module radio_register_write_shadow_core import rrws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp,
  input  logic log_enable_we,
  input  logic log_enable_wdata
);

  logic log_enable;
  logic long_range_mode, sleep_mode, shared_access;
  logic long_range_mode_next, sleep_mode_next, shared_access_next;

  req_t req_q;
  logic req_vld;

  logic is_write, is_opmode, is_mode_reset, low_zero, bank;
  lookup_t lk;
  shd_ctrl_t shd_ctrl;

  rsp_t s2_rsp;
  logic s2_vld, s2_wrote;
  logic [7:0] s2_wdata;
  logic rd_valid;
  logic [7:0] rd_data;
  logic entry_live;
  rsp_t rsp_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_enable <= 1'b1;
    end else if (log_enable_we) begin
      log_enable <= log_enable_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start && !busy;
    end
    req_q <= req;
  end

  assign is_write = req_q.cmd == CMD_WRITE;
  assign is_opmode = is_write && req_q.reg_address == OPMODE_ADDR;
  assign is_mode_reset = req_q.cmd == CMD_MODE_RESET;
  assign low_zero = req_q.write_data[2:0] == 3'd0;

  always_comb begin
    long_range_mode_next = long_range_mode;
    sleep_mode_next = sleep_mode;
    shared_access_next = shared_access;
    if (is_mode_reset) begin
      long_range_mode_next = 1'b0;
      sleep_mode_next = 1'b0;
      shared_access_next = 1'b0;
    end else if (is_opmode) begin
      if (sleep_mode) begin
        if (req_q.write_data[7]) begin
          long_range_mode_next = 1'b1;
        end else if (low_zero) begin
          long_range_mode_next = 1'b0;
        end
      end
      sleep_mode_next = low_zero;
      shared_access_next = long_range_mode_next && req_q.write_data[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_range_mode <= 1'b0;
      sleep_mode <= 1'b0;
      shared_access <= 1'b0;
    end else if (req_vld) begin
      long_range_mode <= long_range_mode_next;
      sleep_mode <= sleep_mode_next;
      shared_access <= shared_access_next;
    end
  end

  assign bank = (req_q.cmd == CMD_READ) ? req_q.read_bank : long_range_mode_next;
  assign lk = rrws_lookup(bank, req_q.reg_address);

  always_comb begin
    shd_ctrl.clear = req_vld && req_q.cmd == CMD_CLEAR;
    shd_ctrl.we = req_vld && is_write && lk.known && log_enable;
    shd_ctrl.bank = bank;
    shd_ctrl.idx = lk.idx;
    shd_ctrl.wdata = req_q.write_data;
  end

  rrws_shadow u_shadow (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (shd_ctrl),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= req_vld;
    end
    s2_rsp.bank_used <= bank;
    s2_rsp.shared_page <= bank && long_range_mode_next && shared_access_next &&
                          req_q.reg_address >= SHARED_LO && req_q.reg_address <= SHARED_HI;
    s2_rsp.low_freq_range <= req_q.reg_address >= LF_LO && req_q.reg_address <= LF_HI;
    s2_rsp.known_register <= lk.known;
    s2_rsp.entry_index <= lk.idx;
    s2_rsp.written_flag <= 1'b0;
    s2_rsp.shadow_value <= '0;
    s2_wrote <= shd_ctrl.we;
    s2_wdata <= req_q.write_data;
  end

  assign entry_live = s2_rsp.known_register && (s2_wrote || rd_valid);

  always_comb begin
    rsp_next = s2_rsp;
    rsp_next.written_flag = entry_live;
    rsp_next.shadow_value = !entry_live ? 8'd0 : (s2_wrote ? s2_wdata : rd_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_vld;
    end
    rsp <= rsp_next;
  end

endmodule

FILE: rtl/rrws_shadow.sv
module rrws_shadow import rrws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  shd_ctrl_t ctrl,
  output logic      rd_valid,
  output logic [7:0] rd_data
);

  logic [7:0] lr_mem [LR_COUNT];
  logic [7:0] fsk_mem [FSK_COUNT];
  logic [LR_COUNT-1:0] lr_valid;
  logic [FSK_COUNT-1:0] fsk_valid;
  logic [LR_IDX_W-1:0] lr_idx;
  logic [FSK_IDX_W-1:0] fsk_idx;

  assign lr_idx = ctrl.idx[LR_IDX_W-1:0];
  assign fsk_idx = ctrl.idx[FSK_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.we && ctrl.bank) begin
      lr_mem[lr_idx] <= ctrl.wdata;
    end
    if (ctrl.we && !ctrl.bank) begin
      fsk_mem[fsk_idx] <= ctrl.wdata;
    end
    rd_data <= ctrl.bank ? lr_mem[lr_idx] : fsk_mem[fsk_idx];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      lr_valid <= '0;
      fsk_valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctrl.we && ctrl.bank) begin
        lr_valid[lr_idx] <= 1'b1;
      end
      if (ctrl.we && !ctrl.bank) begin
        fsk_valid[fsk_idx] <= 1'b1;
      end
      rd_valid <= ctrl.bank ? lr_valid[lr_idx] : fsk_valid[fsk_idx];
    end
  end

endmodule

FILE: rtl/rrws_checker.sv
`include "radio_register_write_shadow_core_assert.svh"

module rrws_checker import rrws_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input rsp_t rsp
);

  `RRWS_ASSERT_DELAY(a_result_follows_request, start && !busy, 3, done, "request lost")
  `RRWS_ASSERT(a_unknown_is_zero, !(done && !rsp.known_register) || (rsp.entry_index == '0 && !rsp.written_flag && rsp.shadow_value == '0), "unknown register result not zero")
  `RRWS_ASSERT(a_written_needs_known, !(done && rsp.written_flag) || rsp.known_register, "written mark on unknown register")
  `RRWS_ASSERT(a_lr_index_range, !(done && rsp.known_register && rsp.bank_used) || rsp.entry_index < IDX_W'(LR_COUNT), "long-range index out of range")

endmodule

bind radio_register_write_shadow_core rrws_checker u_rrws_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
